[rtl/fmtt_pkg.sv]
package fmtt_pkg;

  // Default sizes of the record ring and of the stage average table.
  localparam int RING_DEPTH_DEF  = 16;
  localparam int STAGE_COUNT_DEF = 7;

  // Markers per frame record and fixed point format of the averages.
  localparam int MARKS     = 7;
  localparam int FRAC_BITS = 8;

  // Smoothing weight: unsigned Q1.16, where 65536 stands for one.
  localparam int ALPHA_W = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;

  // Request commands.
  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] frame_id;
    logic [3:0]  marker_code;
    logic [63:0] timestamp_us;
  } request_t;

  typedef struct packed {
    logic        found;
    logic [63:0] input_sample_us;
    logic [63:0] sim_start_us;
    logic [63:0] sim_end_us;
    logic [63:0] submit_start_us;
    logic [63:0] submit_end_us;
    logic [63:0] present_start_us;
    logic [63:0] present_end_us;
    logic [63:0] stage_average_us;
    logic        stage_is_seeded;
  } result_t;

endpackage

[rtl/fmtt_ram.sv]
module fmtt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual port: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/frame_marker_timestamp_table.sv]
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  -----------------------------------------
// in       to block   in_valid / in_stall  in_item   (request_t: command, id, code, time)
// out      from block out_valid/out_stall  out_item  (result_t: found, 7 stamps, average)
// cfg      to block   cfg_valid/cfg_ready  cfg_alpha (smoothing weight, Q1.16)
//
// Sequencing: one request at a time, taken in idle. The id search reads one ring slot a cycle;
// a set of a stage marker then seeds or updates the average (previous stamp, difference,
// two multiplier halves, sum, apply), a set of a new frame clears a new record, a query
// reads the stamps, a read fetches the stage average, and a result goes into the output
// register. Reset is synchronous: head, fill, seeded bits, sequencer, out_valid
// clear and alpha returns to 6554. in_stall is high while a request is in progress.
module frame_marker_timestamp_table #(
  parameter int RING_DEPTH  = fmtt_pkg::RING_DEPTH_DEF,
  parameter int STAGE_COUNT = fmtt_pkg::STAGE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fmtt_pkg::request_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fmtt_pkg::result_t              out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fmtt_pkg::ALPHA_W-1:0]   cfg_alpha
);
  import fmtt_pkg::*;

  // Widths of the slot index, the fill count, the stage index and the stamp address.
  localparam int SW          = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW          = $clog2(RING_DEPTH + 1);
  localparam int SUMW        = FW + 1;
  localparam int ST_W        = $clog2(STAGE_COUNT);
  localparam int SA_W        = SW + 3;
  localparam int STAMP_DEPTH = (2 ** SW) * 8;

  localparam logic [FW-1:0]   FILL_FULL  = FW'(RING_DEPTH);
  localparam logic [SUMW-1:0] DEPTH_S    = SUMW'(RING_DEPTH);
  localparam logic [SW-1:0]   SLOT_LAST  = SW'(RING_DEPTH - 1);
  localparam logic [3:0]      STAGES_C   = 4'(STAGE_COUNT);
  localparam logic [3:0]      MARKS_C    = 4'(MARKS);
  localparam logic [2:0]      MARK_LAST  = 3'(MARKS - 1);
  localparam logic [63:0]     IV_LIMIT   = {64{1'b1}} >> FRAC_BITS;
  localparam logic [80:0]     ROUND_HALF = 81'h8000;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_CLEAR  = 4'd2;
  localparam logic [3:0] S_PREV   = 4'd3;
  localparam logic [3:0] S_DIFF   = 4'd4;
  localparam logic [3:0] S_MUL_LO = 4'd5;
  localparam logic [3:0] S_MUL_HI = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_APPLY  = 4'd8;
  localparam logic [3:0] S_QREAD  = 4'd9;
  localparam logic [3:0] S_AISSUE = 4'd10;
  localparam logic [3:0] S_AREAD  = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  // Control state.
  logic [3:0]             state;
  logic [SW-1:0]          head;
  logic [FW-1:0]          fill;
  logic [FW-1:0]          k;
  logic                   pend;
  logic [3:0]             cnt;
  logic                   qpend;
  logic [STAGE_COUNT-1:0] seeded;
  logic [ALPHA_W-1:0]     alpha;

  // Datapath registers.
  request_t    req;
  logic [SW-1:0] pend_slot;
  logic [SW-1:0] slot;
  logic [2:0]  qidx;
  logic [63:0] stamp_q [MARKS];
  logic        res_found;
  logic [63:0] res_avg;
  logic        res_seeded;
  logic [63:0] iv_q;
  logic [63:0] avg_q;
  logic [63:0] d_q;
  logic        up_q;
  logic [48:0] prod_lo;
  logic [48:0] prod_hi;
  logic [63:0] step_q;

  // Memory ports.
  logic            id_wr_en;
  logic [SW-1:0]   id_wr_addr;
  logic            id_rd_en;
  logic [63:0]     id_rd_data;
  logic            st_wr_en;
  logic [SA_W-1:0] st_wr_addr;
  logic [63:0]     st_wr_data;
  logic            st_rd_en;
  logic [SA_W-1:0] st_rd_addr;
  logic [63:0]     st_rd_data;
  logic            av_wr_en;
  logic [63:0]     av_wr_data;
  logic            av_rd_en;
  logic [63:0]     av_rd_data;

  // Decoded request and search signals.
  logic [SUMW-1:0]    ssum;
  logic [SW-1:0]      cur_slot;
  logic [SW-1:0]      alloc_slot;
  logic [SW-1:0]      head_inc;
  logic               hit;
  logic               search_more;
  logic               miss;
  logic               is_set;
  logic               is_stage;
  logic [2:0]         code3;
  logic [2:0]         code_m1;
  logic [ST_W-1:0]    stage_idx;
  logic               in_accept;
  logic               out_load;

  // Interval and averaging arithmetic.
  logic [63:0]        interval;
  logic               iv_ok;
  logic [63:0]        iv_c;
  logic               seed_wr;
  logic [ALPHA_W-1:0] alpha_eff;
  logic [31:0]        mul_op;
  logic [48:0]        mul_res;
  logic [80:0]        sum_full;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_EMIT) && (!out_valid || !out_stall);

  assign is_set    = (req.command == CMD_SET);
  assign code3     = req.marker_code[2:0];
  assign code_m1   = code3 - 3'd1;
  assign stage_idx = req.marker_code[ST_W-1:0];
  assign is_stage  = (req.marker_code != 4'd0) && (req.marker_code < STAGES_C);

  // The search walks the valid records from the oldest one. Slot k of the walk is
  // head+k, wrapped once around the ring.
  assign ssum        = SUMW'(head) + SUMW'(k);
  assign cur_slot    = (ssum >= DEPTH_S) ? SW'(ssum - DEPTH_S) : SW'(ssum);
  assign search_more = (k < fill);
  assign hit         = (state == S_SEARCH) && pend && (id_rd_data == req.frame_id);
  assign miss        = (state == S_SEARCH) && !pend && !search_more;
  // When the walk ends without a hit, k equals fill, so cur_slot is the first free slot.
  // A full ring reuses the oldest slot instead.
  assign alloc_slot  = (fill == FILL_FULL) ? head : cur_slot;
  assign head_inc    = (head == SLOT_LAST) ? '0 : head + SW'(1);

  // Interval between this marker and the previous one of the same frame, turned into
  // 8 fraction bits with saturation.
  assign interval = req.timestamp_us - st_rd_data;
  assign iv_ok    = (st_rd_data != 64'd0) && (req.timestamp_us > st_rd_data);
  assign iv_c     = (interval > IV_LIMIT) ? {64{1'b1}} : (interval << FRAC_BITS);
  assign seed_wr  = (state == S_PREV) && iv_ok && !seeded[stage_idx];

  // Weights above one act as one. The 64 by 17 bit product is formed from two halves
  // on one shared 32 by 17 bit multiplier, and the step rounds half up.
  assign alpha_eff = alpha[ALPHA_W-1] ? ALPHA_ONE : alpha;
  assign mul_op    = (state == S_MUL_HI) ? d_q[63:32] : d_q[31:0];
  assign mul_res   = 49'(mul_op) * 49'(alpha_eff);
  assign sum_full  = 81'(prod_lo) + {prod_hi, 32'd0} + ROUND_HALF;

  // Id memory: read during the walk, written on allocation.
  assign id_rd_en   = (state == S_SEARCH) && !hit && search_more;
  assign id_wr_en   = miss && is_set;
  assign id_wr_addr = alloc_slot;

  // Stamp memory, addressed by slot and marker. The previous marker is read in the
  // cycle of the hit while the new stamp is written to its own entry.
  always_comb begin
    st_rd_en   = (hit && is_set && is_stage) || ((state == S_QREAD) && (cnt < MARKS_C));
    st_rd_addr = (state == S_QREAD) ? {slot, cnt[2:0]} : {pend_slot, code_m1};
    st_wr_en   = (hit && is_set) || (state == S_CLEAR);
    st_wr_addr = (state == S_CLEAR) ? {slot, cnt[2:0]} : {pend_slot, code3};
    st_wr_data = ((state == S_CLEAR) && (cnt[2:0] != code3)) ? 64'd0 : req.timestamp_us;
  end

  // Stage average memory. An entry is meaningful only once its seeded bit is set.
  always_comb begin
    av_rd_en   = (hit && is_set && is_stage) || (state == S_AISSUE);
    av_wr_en   = seed_wr || (state == S_APPLY);
    av_wr_data = iv_c;
    if (state == S_APPLY) begin
      av_wr_data = up_q ? (avg_q + step_q) : (avg_q - step_q);
    end
  end

  fmtt_ram #(
    .WIDTH (64),
    .DEPTH (RING_DEPTH)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (id_wr_en),
    .wr_addr (id_wr_addr),
    .wr_data (req.frame_id),
    .rd_en   (id_rd_en),
    .rd_addr (cur_slot),
    .rd_data (id_rd_data)
  );

  fmtt_ram #(
    .WIDTH (64),
    .DEPTH (STAMP_DEPTH)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  fmtt_ram #(
    .WIDTH (64),
    .DEPTH (STAGE_COUNT)
  ) u_avg_ram (
    .clk     (clk),
    .wr_en   (av_wr_en),
    .wr_addr (stage_idx),
    .wr_data (av_wr_data),
    .rd_en   (av_rd_en),
    .rd_addr (stage_idx),
    .rd_data (av_rd_data)
  );

  // Requests run one after another, and every memory write of a request lands before
  // the sequencer returns to idle, so no read ever meets a write still in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      k         <= '0;
      pend      <= 1'b0;
      cnt       <= '0;
      qpend     <= 1'b0;
      seeded    <= '0;
      alpha     <= ALPHA_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        alpha <= cfg_alpha;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            req   <= in_item;
            k     <= '0;
            pend  <= 1'b0;
            cnt   <= '0;
            qpend <= 1'b0;
            case (in_item.command)
              CMD_SET: begin
                // Marker codes past the last marker are dropped here.
                state <= (in_item.marker_code < MARKS_C) ? S_SEARCH : S_IDLE;
              end
              CMD_QUERY: begin
                state <= S_SEARCH;
              end
              CMD_READ: begin
                state <= S_AISSUE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_SEARCH: begin
          if (hit) begin
            slot <= pend_slot;
            if (is_set) begin
              state <= is_stage ? S_PREV : S_IDLE;
            end else begin
              state <= S_QREAD;
            end
          end else if (search_more) begin
            pend      <= 1'b1;
            pend_slot <= cur_slot;
            k         <= k + FW'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else if (is_set) begin
            // Allocate: the new marker goes in during the clearing sweep.
            slot <= alloc_slot;
            cnt  <= '0;
            if (fill == FILL_FULL) begin
              head <= head_inc;
            end else begin
              fill <= fill + FW'(1);
            end
            state <= S_CLEAR;
          end else begin
            res_found  <= 1'b0;
            res_avg    <= '0;
            res_seeded <= 1'b0;
            stamp_q    <= '{default: '0};
            state      <= S_EMIT;
          end
        end

        S_CLEAR: begin
          cnt <= cnt + 4'd1;
          if (cnt[2:0] == MARK_LAST) begin
            state <= S_IDLE;
          end
        end

        S_PREV: begin
          if (iv_ok) begin
            if (seeded[stage_idx]) begin
              iv_q  <= iv_c;
              avg_q <= av_rd_data;
              state <= S_DIFF;
            end else begin
              seeded[stage_idx] <= 1'b1;
              state             <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end

        S_DIFF: begin
          up_q  <= (iv_q >= avg_q);
          d_q   <= (iv_q >= avg_q) ? (iv_q - avg_q) : (avg_q - iv_q);
          state <= S_MUL_LO;
        end

        S_MUL_LO: begin
          prod_lo <= mul_res;
          state   <= S_MUL_HI;
        end

        S_MUL_HI: begin
          prod_hi <= mul_res;
          state   <= S_SUM;
        end

        S_SUM: begin
          step_q <= sum_full[79:16];
          state  <= S_APPLY;
        end

        S_APPLY: begin
          state <= S_IDLE;
        end

        S_QREAD: begin
          if (qpend) begin
            stamp_q[qidx] <= st_rd_data;
          end
          if (cnt < MARKS_C) begin
            qpend <= 1'b1;
            qidx  <= cnt[2:0];
            cnt   <= cnt + 4'd1;
          end else if (qpend) begin
            qpend <= 1'b0;
          end else begin
            res_found  <= 1'b1;
            res_avg    <= '0;
            res_seeded <= 1'b0;
            state      <= S_EMIT;
          end
        end

        S_AISSUE: begin
          state <= S_AREAD;
        end

        S_AREAD: begin
          res_found <= 1'b0;
          stamp_q   <= '{default: '0};
          if ((req.marker_code < STAGES_C) && seeded[stage_idx]) begin
            res_avg    <= av_rd_data;
            res_seeded <= 1'b1;
          end else begin
            res_avg    <= '0;
            res_seeded <= 1'b0;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register, loaded from the finished result.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.found            <= res_found;
      out_item.input_sample_us  <= stamp_q[0];
      out_item.sim_start_us     <= stamp_q[1];
      out_item.sim_end_us       <= stamp_q[2];
      out_item.submit_start_us  <= stamp_q[3];
      out_item.submit_end_us    <= stamp_q[4];
      out_item.present_start_us <= stamp_q[5];
      out_item.present_end_us   <= stamp_q[6];
      out_item.stage_average_us <= res_avg;
      out_item.stage_is_seeded  <= res_seeded;
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never runs past the ring.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("ring fill count beyond ring depth");

  // The oldest record stays in slot zero until the ring has filled once.
  a_head_until_full: assert property (@(posedge clk) disable iff (rst)
    (fill != FILL_FULL) |-> (head == '0))
    else $error("ring head moved before the ring was full");

  // The walk never reads beyond the valid records.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (k <= fill))
    else $error("search walked past the fill count");

  // A blended update only happens for a stage that has been seeded.
  a_apply_seeded: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> seeded[stage_idx])
    else $error("average blended into an unseeded stage");

  // A new result appears only from the emit state.
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("result shown without passing through emit");
`endif

endmodule
